### hw/rtl/stfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfb_pkg
// Shared widths, constants and elaboration-time helpers for the star
// triangle feature builder.
// ----------------------------------------------------------------------------
package stfb_pkg;

  localparam int ID_W             = 18;
  localparam int COORD_W          = 16;
  localparam int SIDE_W           = 16;
  localparam int PHI_W            = 24;
  localparam int ACOS_DEPTH_DEF   = 1024;
  localparam int SEP_LAT          = 10;
  localparam logic [SIDE_W-1:0] MAX_SEP_RST = 16'd5120;
  localparam logic [SIDE_W-1:0] SIDE_MAX    = 16'd46080;
  localparam logic [PHI_W-1:0]  DEG180_Q16  = 24'd11796480;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic longint cordic_atan(input int i);
    longint a;
    case (i)
      0:  a = 2949120;
      1:  a = 1740967;
      2:  a = 919879;
      3:  a = 466945;
      4:  a = 234379;
      5:  a = 117304;
      6:  a = 58666;
      7:  a = 29335;
      8:  a = 14668;
      9:  a = 7334;
      10: a = 3667;
      11: a = 1833;
      12: a = 917;
      13: a = 458;
      14: a = 229;
      15: a = 115;
      default: a = 0;
    endcase
    return a;
  endfunction

  // bit-pair integer square root, elaboration use only
  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bit_v;
    rem   = v;
    res   = 0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2*asin(yq/2^16) in 1/65536 degree via vectoring cordic
  function automatic logic [PHI_W-1:0] arc_entry(input longint unsigned yq);
    longint unsigned xq;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    xq = isqrt64((64'd1 << 32) - yq * yq);
    x  = longint'(xq << 14);
    y  = longint'(yq << 14);
    z  = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + cordic_atan(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - cordic_atan(i);
      end
    end
    if (z < 0) begin
      z = 0;
    end
    return PHI_W'(2 * z);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/stfb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfb_in_if
// Candidate triple channel: three stars, id and Q1.15 direction each.
// ----------------------------------------------------------------------------
interface stfb_in_if;
  logic             valid;
  logic             ready;
  stfb_pkg::id_t    first_id;
  stfb_pkg::coord_t first_x;
  stfb_pkg::coord_t first_y;
  stfb_pkg::coord_t first_z;
  stfb_pkg::id_t    second_id;
  stfb_pkg::coord_t second_x;
  stfb_pkg::coord_t second_y;
  stfb_pkg::coord_t second_z;
  stfb_pkg::id_t    third_id;
  stfb_pkg::coord_t third_x;
  stfb_pkg::coord_t third_y;
  stfb_pkg::coord_t third_z;

  modport source (
    output valid, first_id, first_x, first_y, first_z,
    second_id, second_x, second_y, second_z,
    third_id, third_x, third_y, third_z,
    input ready
  );
  modport sink (
    input valid, first_id, first_x, first_y, first_z,
    second_id, second_x, second_y, second_z,
    third_id, third_x, third_y, third_z,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/stfb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfb_out_if
// Triangle feature channel: ordered vertex ids and side lengths.
// ----------------------------------------------------------------------------
interface stfb_out_if;
  logic            valid;
  logic            ready;
  stfb_pkg::id_t   vertex_a_id;
  stfb_pkg::id_t   vertex_b_id;
  stfb_pkg::id_t   vertex_c_id;
  stfb_pkg::side_t short_side;
  stfb_pkg::side_t middle_side;
  stfb_pkg::side_t long_side;

  modport source (
    output valid, vertex_a_id, vertex_b_id, vertex_c_id,
    short_side, middle_side, long_side,
    input ready
  );
  modport sink (
    input valid, vertex_a_id, vertex_b_id, vertex_c_id,
    short_side, middle_side, long_side,
    output ready
  );
endinterface
`default_nettype wire

### hw/rtl/stfb_sep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stfb_sep
// Ten-stage angular separation pipe: dot product, half-angle square root,
// arc table lookup with interpolation, rounding to 1/256 degree.
// ----------------------------------------------------------------------------
module stfb_sep #(
  parameter int ACOS_TABLE_DEPTH = stfb_pkg::ACOS_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire stfb_pkg::coord_t ax,
  input  wire stfb_pkg::coord_t ay,
  input  wire stfb_pkg::coord_t az,
  input  wire stfb_pkg::coord_t bx,
  input  wire stfb_pkg::coord_t by,
  input  wire stfb_pkg::coord_t bz,
  output stfb_pkg::side_t       sep
);

  localparam int IDX_W = $clog2(ACOS_TABLE_DEPTH + 1);
  localparam int POS_W = 16 + IDX_W;
  localparam int PW    = stfb_pkg::PHI_W;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef logic [PW-1:0] rom_t [0:ACOS_TABLE_DEPTH];

  typedef struct packed {
    logic [18:0] rem;
    logic [15:0] root;
    logic [31:0] rad;
  } sq_t;

  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned yq;
    for (int k = 0; k <= ACOS_TABLE_DEPTH; k++) begin
      yq   = (longint'(k) << 16) / ACOS_TABLE_DEPTH;
      r[k] = stfb_pkg::arc_entry(yq);
    end
    return r;
  endfunction

  localparam rom_t ARC_ROM = build_rom();

  // four result bits of the square root
  function automatic sq_t sq_steps(input sq_t s);
    sq_t o;
    logic [18:0] trial;
    o = s;
    for (int i = 0; i < 4; i++) begin
      o.rem = {o.rem[16:0], o.rad[31:30]};
      o.rad = {o.rad[29:0], 2'b00};
      trial = {1'b0, o.root, 2'b01};
      if (o.rem >= trial) begin
        o.rem  = o.rem - trial;
        o.root = {o.root[14:0], 1'b1};
      end else begin
        o.root = {o.root[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic signed [31:0] p0_r, p1_r, p2_r;
  logic signed [33:0] dot;
  logic signed [33:0] dcl;
  logic signed [33:0] rad_w;
  logic [7:0]         neg_sr_r;
  sq_t                sq_r [0:4];
  logic [POS_W-1:0]   pos_r;
  logic [IDX_W-1:0]   idx;
  logic [PW-1:0]      lo_r, hi_r, lo2_r;
  logic [15:0]        frac_r;
  logic               up_r;
  logic [PW+15:0]     prod_r;
  logic [PW:0]        adj;
  logic [PW-1:0]      phi;
  logic [PW-1:0]      theta;
  logic [PW-9:0]      rnd;
  stfb_pkg::side_t    sep_r;

  always_comb begin
    dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    dcl = dot;
    if (dot > ONE_Q30) begin
      dcl = ONE_Q30;
    end else if (dot < -ONE_Q30) begin
      dcl = -ONE_Q30;
    end
    if (dcl < 0) begin
      rad_w = (ONE_Q30 + dcl) <<< 1;
    end else begin
      rad_w = (ONE_Q30 - dcl) <<< 1;
    end
  end

  assign idx = pos_r[POS_W-1:16];

  always_comb begin
    adj   = (PW+1)'((prod_r + (PW+16)'(32768)) >> 16);
    phi   = up_r ? PW'(lo2_r + adj) : PW'(lo2_r - adj);
    theta = phi;
    if (neg_sr_r[7]) begin
      theta = (phi <= stfb_pkg::DEG180_Q16) ? (stfb_pkg::DEG180_Q16 - phi) : '0;
    end
    rnd = (PW-8)'((theta + PW'(128)) >> 8);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= ax * bx;
      p1_r <= ay * by;
      p2_r <= az * bz;
      neg_sr_r      <= {neg_sr_r[6:0], dcl < 0};
      sq_r[0].rem   <= '0;
      sq_r[0].root  <= '0;
      sq_r[0].rad   <= rad_w[31:0];
      for (int s = 0; s < 4; s++) begin
        sq_r[s+1] <= sq_steps(sq_r[s]);
      end
      pos_r  <= POS_W'(sq_r[4].root) * POS_W'(ACOS_TABLE_DEPTH);
      lo_r   <= ARC_ROM[idx];
      hi_r   <= ARC_ROM[idx + IDX_W'(1)];
      frac_r <= pos_r[15:0];
      // interpolation direction flag
      up_r   <= 1'b0;
      if (hi_r >= lo_r) begin
        up_r <= 1'b1;
      end
      lo2_r  <= lo_r;
      sep_r  <= (rnd > (PW-8)'(stfb_pkg::SIDE_MAX)) ? stfb_pkg::SIDE_MAX
                                                    : stfb_pkg::side_t'(rnd);
    end
  end

  // split so the direction flag lines up with the product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (PW+16)'(((hi_r >= lo_r) ? (hi_r - lo_r) : (lo_r - hi_r))) *
                (PW+16)'(frac_r);
    end
  end

  assign sep = sep_r;

endmodule
`default_nettype wire

### hw/rtl/star_triangle_feature_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// star_triangle_feature_builder
// Turns one candidate star triple into an ordered triangle feature.
// ----------------------------------------------------------------------------
// in_ch carries one triple per beat; out_ch carries zero or one triangle per
// triple, in order. cfg_we/cfg_wdata write the separation limit (1/256 deg),
// to be changed only while no triple is in flight.
// Throughput: one triple per cycle unless out_ch stalls. A triple passes
// from the input beat to out_ch.valid through the separation pipe: products,
// dot sum, four square root stages, table address, table read, interpolation
// multiply, rounding, then the filter and sort stage (the output register).
// Triples that fail the limit drop out silently.
// Reset (rst_n low at a clock edge) empties the pipe and sets the limit to
// 20 degrees; the arc table is constant and needs no fill.
// When out_ch.ready is low with a result held, the whole pipe holds and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module star_triangle_feature_builder #(
  parameter int ACOS_TABLE_DEPTH = stfb_pkg::ACOS_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  stfb_in_if.sink          in_ch,
  stfb_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int LAT = stfb_pkg::SEP_LAT;

  typedef stfb_pkg::id_t ids_t [0:2];

  logic                  en;
  logic [LAT-1:0]        v_r;
  ids_t                  ids_r [0:LAT-1];
  stfb_pkg::side_t       max_sep_r;
  stfb_pkg::side_t       s01, s12, s20;
  logic                  pass;
  stfb_pkg::id_t         sid [0:2];
  stfb_pkg::side_t       sop [0:2];
  stfb_pkg::id_t         tid;
  stfb_pkg::side_t       top;
  logic                  out_valid_r;
  stfb_pkg::id_t         a_id_r, b_id_r, c_id_r;
  stfb_pkg::side_t       short_r, middle_r, long_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  stfb_sep #(.ACOS_TABLE_DEPTH(ACOS_TABLE_DEPTH)) u_sep01 (
    .clk(clk), .en(en),
    .ax(in_ch.first_x), .ay(in_ch.first_y), .az(in_ch.first_z),
    .bx(in_ch.second_x), .by(in_ch.second_y), .bz(in_ch.second_z),
    .sep(s01)
  );
  stfb_sep #(.ACOS_TABLE_DEPTH(ACOS_TABLE_DEPTH)) u_sep12 (
    .clk(clk), .en(en),
    .ax(in_ch.second_x), .ay(in_ch.second_y), .az(in_ch.second_z),
    .bx(in_ch.third_x), .by(in_ch.third_y), .bz(in_ch.third_z),
    .sep(s12)
  );
  stfb_sep #(.ACOS_TABLE_DEPTH(ACOS_TABLE_DEPTH)) u_sep20 (
    .clk(clk), .en(en),
    .ax(in_ch.third_x), .ay(in_ch.third_y), .az(in_ch.third_z),
    .bx(in_ch.first_x), .by(in_ch.first_y), .bz(in_ch.first_z),
    .sep(s20)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sep_r <= stfb_pkg::MAX_SEP_RST;
    end else if (cfg_we) begin
      max_sep_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ids_r[0][0] <= in_ch.first_id;
      ids_r[0][1] <= in_ch.second_id;
      ids_r[0][2] <= in_ch.third_id;
      for (int s = 1; s < LAT; s++) begin
        ids_r[s] <= ids_r[s-1];
      end
    end
  end

  // three compare-and-swap steps, swap only on strictly greater
  always_comb begin
    tid    = '0;
    top    = '0;
    pass   = (s01 <= max_sep_r) && (s20 < max_sep_r) && (s12 < max_sep_r);
    sid[0] = ids_r[LAT-1][0]; sop[0] = s12;
    sid[1] = ids_r[LAT-1][1]; sop[1] = s20;
    sid[2] = ids_r[LAT-1][2]; sop[2] = s01;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        if (sop[1] > sop[2]) begin
          tid = sid[1]; top = sop[1];
          sid[1] = sid[2]; sop[1] = sop[2];
          sid[2] = tid; sop[2] = top;
        end
      end else begin
        if (sop[0] > sop[1]) begin
          tid = sid[0]; top = sop[0];
          sid[0] = sid[1]; sop[0] = sop[1];
          sid[1] = tid; sop[1] = top;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[LAT-1] && pass;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_id_r   <= sid[0];
      b_id_r   <= sid[1];
      c_id_r   <= sid[2];
      short_r  <= sop[0];
      middle_r <= sop[1];
      long_r   <= sop[2];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.vertex_a_id = a_id_r;
  assign out_ch.vertex_b_id = b_id_r;
  assign out_ch.vertex_c_id = c_id_r;
  assign out_ch.short_side  = short_r;
  assign out_ch.middle_side = middle_r;
  assign out_ch.long_side   = long_r;

`ifndef NO_ASSERTIONS
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (short_r <= middle_r) && (middle_r <= long_r))
    else $error("triangle sides out of order");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (long_r <= max_sep_r))
    else $error("emitted side above limit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipe moved during stall");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && (v_r == '0))
    else $error("pipe not empty after reset");
`endif

endmodule
`default_nettype wire
